FILE: src/gbts_pkg.sv
`timescale 1ns / 1ps

package gbts_pkg;

	localparam int ACT_W  = 3;
	localparam int CHAR_W = 8;
	localparam int POS_W  = 10;
	localparam int CNT_W  = 11;
	localparam int ST_W   = 2;

	typedef logic [ACT_W-1:0]  action_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [ST_W-1:0]   status_t;

	localparam action_t ACT_INSERT = 3'd0;
	localparam action_t ACT_DELETE = 3'd1;
	localparam action_t ACT_LEFT   = 3'd2;
	localparam action_t ACT_RIGHT  = 3'd3;
	localparam action_t ACT_READ   = 3'd4;

	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EDGE  = 2'd2;
	localparam status_t ST_RANGE = 2'd3;

endpackage

FILE: src/gap_buffer_text_store.sv
`timescale 1ns / 1ps

// Gap buffer text store: editable text of 8-bit characters in a single
// synchronous RAM of CAPACITY entries, split by a gap [gap_start, gap_end).
// Input channel (in_valid/in_ready): action, data_char, position. Actions are
// insert at cursor, delete before cursor, move left, move right, read at a
// logical text position. Output channel (out_valid/out_ready): one result
// per transfer with read_char, status, cursor and text_length after the
// action.
// Each item passes from accept to completion, where its result enters the
// output register. The RAM read is issued in the accept cycle; completion
// uses the registered read data (read result, or the copy across the gap
// for a move, written back in that same cycle). Inserts write in the accept
// cycle. One item is in flight at a time, so a new item is not accepted
// until the last one has completed.
// Reset clears the gap to span the whole store and empties the output
// register; RAM contents are not cleared and need no clearing pass.
// When the receiver stalls, a finished result waits in the output register
// while the next item is still accepted; that item then waits to complete
// until the output register frees up.
module gap_buffer_text_store #(
	parameter int CAPACITY = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  gbts_pkg::action_t        action,
	input  gbts_pkg::char_t          data_char,
	input  gbts_pkg::pos_t           position,
	output logic                     out_valid,
	input  logic                     out_ready,
	output gbts_pkg::char_t          read_char,
	output gbts_pkg::status_t        status,
	output gbts_pkg::count_t         cursor,
	output gbts_pkg::count_t         text_length
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int PW   = $clog2(CAPACITY + 1);
	// compare width: room for position and pointer sums without overflow
	localparam int CMPW = (PW > gbts_pkg::POS_W) ? PW + 1 : gbts_pkg::CNT_W;
	localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

	// gap bookkeeping, updated at accept
	logic [PW-1:0] gs_q, ge_q;

	// item in flight (awaiting completion)
	logic                busy_q;
	logic                move_wr_q;   // write rdata across the gap on completion
	logic                rd_use_q;    // result carries rdata
	logic [AW-1:0]       wr_addr_q;
	gbts_pkg::status_t   st_q;

	// output register
	logic                out_valid_q;
	gbts_pkg::char_t     read_char_q;
	gbts_pkg::status_t   status_q;
	gbts_pkg::count_t    cursor_q, length_q;

	// RAM
	gbts_pkg::char_t     mem [CAPACITY];
	gbts_pkg::char_t     rdata_q;
	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	gbts_pkg::char_t     mem_wdata;

	logic accept, complete;
	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign complete = busy_q && (!out_valid_q || out_ready);

	// next-state decode for the accepted item
	logic [PW-1:0]     gap_w, held_w;
	logic [CMPW-1:0]   pos_x, held_x, gs_x, gap_x, rd_sum;
	logic [PW-1:0]     gs_d, ge_d;
	logic              ins_ok, mv_ok, rd_ok;
	logic [AW-1:0]     rd_addr, mv_waddr;
	gbts_pkg::status_t st_d;

	assign gap_w  = ge_q - gs_q;
	assign held_w = CAP_P - gap_w;
	assign pos_x  = CMPW'(position);
	assign held_x = CMPW'(held_w);
	assign gs_x   = CMPW'(gs_q);
	assign gap_x  = CMPW'(gap_w);
	assign rd_sum = (pos_x < gs_x) ? pos_x : (pos_x + gap_x);

	always_comb begin
		gs_d     = gs_q;
		ge_d     = ge_q;
		ins_ok   = 1'b0;
		mv_ok    = 1'b0;
		rd_ok    = 1'b0;
		rd_addr  = '0;
		mv_waddr = '0;
		st_d     = gbts_pkg::ST_DONE;
		unique case (action)
			gbts_pkg::ACT_INSERT: begin
				if (gs_q == ge_q) begin
					st_d = gbts_pkg::ST_FULL;
				end else begin
					ins_ok = 1'b1;
					gs_d   = gs_q + PW'(1);
				end
			end
			gbts_pkg::ACT_DELETE: begin
				if (gs_q == '0) begin
					st_d = gbts_pkg::ST_EDGE;
				end else begin
					gs_d = gs_q - PW'(1);
				end
			end
			gbts_pkg::ACT_LEFT: begin
				if (gs_q == '0) begin
					st_d = gbts_pkg::ST_EDGE;
				end else begin
					mv_ok    = 1'b1;
					gs_d     = gs_q - PW'(1);
					ge_d     = ge_q - PW'(1);
					rd_addr  = gs_d[AW-1:0];
					mv_waddr = ge_d[AW-1:0];
				end
			end
			gbts_pkg::ACT_RIGHT: begin
				if (ge_q >= CAP_P) begin
					st_d = gbts_pkg::ST_EDGE;
				end else begin
					mv_ok    = 1'b1;
					gs_d     = gs_q + PW'(1);
					ge_d     = ge_q + PW'(1);
					rd_addr  = ge_q[AW-1:0];
					mv_waddr = gs_q[AW-1:0];
				end
			end
			gbts_pkg::ACT_READ: begin
				if (pos_x >= held_x) begin
					st_d = gbts_pkg::ST_RANGE;
				end else begin
					rd_ok   = 1'b1;
					rd_addr = rd_sum[AW-1:0];
				end
			end
			default: begin
				// unused action codes: no change, done
			end
		endcase
	end

	// RAM port control: insert writes at accept, a move writes on completion
	assign mem_re    = accept && (mv_ok || rd_ok);
	assign mem_raddr = rd_addr;
	assign mem_we    = (accept && ins_ok) || (complete && move_wr_q);
	assign mem_waddr = accept ? gs_q[AW-1:0] : wr_addr_q;
	assign mem_wdata = accept ? data_char : rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q   <= '0;
			ge_q   <= CAP_P;
			busy_q <= 1'b0;
		end else begin
			if (accept) begin
				gs_q   <= gs_d;
				ge_q   <= ge_d;
				busy_q <= 1'b1;
			end else if (complete) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			move_wr_q <= mv_ok;
			rd_use_q  <= rd_ok;
			wr_addr_q <= mv_waddr;
			st_q      <= st_d;
		end
	end

	// cursor and length are reported masked to the field width
	logic [CMPW-1:0] cur_x, len_x;
	assign cur_x = CMPW'(gs_q);
	assign len_x = CMPW'(CAP_P - (ge_q - gs_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (complete) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			read_char_q <= rd_use_q ? rdata_q : '0;
			status_q    <= st_q;
			cursor_q    <= cur_x[gbts_pkg::CNT_W-1:0];
			length_q    <= len_x[gbts_pkg::CNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign read_char   = read_char_q;
	assign status      = status_q;
	assign cursor      = cursor_q;
	assign text_length = length_q;

endmodule

FILE: src/gbts_checker.sv
`timescale 1ns / 1ps

module gbts_checker #(
	parameter int CAPACITY = 1024
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input gbts_pkg::char_t   read_char,
	input gbts_pkg::status_t status,
	input gbts_pkg::count_t  cursor,
	input gbts_pkg::count_t  text_length
);

	localparam logic [31:0] CAP_32 = 32'(CAPACITY);
	localparam gbts_pkg::count_t CAP_M = CAP_32[gbts_pkg::CNT_W-1:0];
	localparam logic SMALL_CAP = (CAPACITY < 2048);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_char)
			&& $stable(cursor) && $stable(text_length))
		else $error("result changed while stalled");

	// one item in flight: no accept in the cycle after a transfer in
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted back to back");

	// refused insert only when the store is full
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == gbts_pkg::ST_FULL |-> text_length == CAP_M)
		else $error("full status with free space");

	// a result with a failing status carries no character
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == gbts_pkg::ST_RANGE || status == gbts_pkg::ST_FULL
			|| status == gbts_pkg::ST_EDGE) |-> read_char == '0)
		else $error("character returned with failing status");

	// cursor never passes the end of the text (checked only for CAPACITY below 2048)
	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && SMALL_CAP |-> cursor <= text_length && text_length <= CAP_M)
		else $error("cursor beyond text");

endmodule

bind gap_buffer_text_store gbts_checker #(.CAPACITY(CAPACITY)) u_gbts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.read_char   (read_char),
	.status      (status),
	.cursor      (cursor),
	.text_length (text_length)
);

FILE: test/tb_gap_buffer_text_store.sv
`timescale 1ns / 1ps

module tb_gap_buffer_text_store;
	// The driver takes edits from a queue and offers them in bursts. At each
	// accepted transfer it runs its own copy of the gap buffer and queues the
	// result it predicts. The monitor checks each result, field by field,
	// against the oldest prediction. The receiver stalls on a rotating pattern.
	// Once it holds off for a long stretch so that the block backs up.

	localparam int CAPACITY = 1024;
	localparam int ITEM_TARGET = 1900;
	localparam int MAX_PRINTS = 100;
	// action codes with no meaning; the block answers "done" and changes nothing
	localparam gbts_pkg::action_t ACT_SPARE_LO  = 3'd5;
	localparam gbts_pkg::action_t ACT_SPARE_MID = 3'd6;
	localparam gbts_pkg::action_t ACT_SPARE_HI  = 3'd7;

	typedef struct {
		gbts_pkg::action_t act;
		gbts_pkg::char_t   ch;
		gbts_pkg::pos_t    pos;
	} edit_item_t;

	typedef struct {
		gbts_pkg::char_t   rd;
		gbts_pkg::status_t st;
		gbts_pkg::count_t  cur;
		gbts_pkg::count_t  len;
	} edit_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	gbts_pkg::action_t action = gbts_pkg::ACT_INSERT;
	gbts_pkg::char_t   data_char = '0;
	gbts_pkg::pos_t    position = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	gbts_pkg::char_t   read_char;
	gbts_pkg::status_t status;
	gbts_pkg::count_t  cursor;
	gbts_pkg::count_t  text_length;

	gap_buffer_text_store #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.data_char(data_char),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_char(read_char),
		.status(status),
		.cursor(cursor),
		.text_length(text_length)
	);

	// edits still to be sent and results still to be seen
	edit_item_t   pending_edits[$];
	edit_result_t expected_results[$];
	int           mismatch_count = 0;
	int           results_seen = 0;
	int           items_queued = 0;

	// mirror of the text store, gap bounds kept as plain integers
	gbts_pkg::char_t text_mirror[CAPACITY];
	int    mirror_gs = 0;
	int    mirror_ge = CAPACITY;

	// gap bounds as seen by the stimulus generator, used only to steer it
	int    plan_gs = 0;
	int    plan_ge = CAPACITY;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	task report_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// Apply one accepted edit to the mirror and queue the result it gives.
	task apply_edit(input gbts_pkg::action_t act, input gbts_pkg::char_t ch,
			input gbts_pkg::pos_t pos);
		edit_result_t res;
		int held;
		res.rd = '0;
		res.st = gbts_pkg::ST_DONE;
		held = CAPACITY - (mirror_ge - mirror_gs);
		case (act)
			gbts_pkg::ACT_INSERT: begin
				if (mirror_gs >= mirror_ge) begin
					res.st = gbts_pkg::ST_FULL;
				end else begin
					text_mirror[mirror_gs] = ch;
					mirror_gs++;
				end
			end
			gbts_pkg::ACT_DELETE: begin
				if (mirror_gs == 0)
					res.st = gbts_pkg::ST_EDGE;
				else
					mirror_gs--;
			end
			gbts_pkg::ACT_LEFT: begin
				// char before the cursor crosses to the far side of the gap
				if (mirror_gs == 0) begin
					res.st = gbts_pkg::ST_EDGE;
				end else begin
					mirror_gs--;
					mirror_ge--;
					text_mirror[mirror_ge] = text_mirror[mirror_gs];
				end
			end
			gbts_pkg::ACT_RIGHT: begin
				if (mirror_ge >= CAPACITY) begin
					res.st = gbts_pkg::ST_EDGE;
				end else begin
					text_mirror[mirror_gs] = text_mirror[mirror_ge];
					mirror_gs++;
					mirror_ge++;
				end
			end
			gbts_pkg::ACT_READ: begin
				// positions at or past the cursor skip over the gap
				if (int'(pos) >= held)
					res.st = gbts_pkg::ST_RANGE;
				else if (int'(pos) < mirror_gs)
					res.rd = text_mirror[pos];
				else
					res.rd = text_mirror[int'(pos) + mirror_ge - mirror_gs];
			end
			default: ;
		endcase
		res.cur = gbts_pkg::count_t'(mirror_gs);
		res.len = gbts_pkg::count_t'(CAPACITY - (mirror_ge - mirror_gs));
		expected_results.push_back(res);
	endtask

	function int plan_len();
		return CAPACITY - (plan_ge - plan_gs);
	endfunction

	// Queue one edit and track the gap bounds it leads to.
	task queue_edit(input gbts_pkg::action_t act, input gbts_pkg::char_t ch,
			input gbts_pkg::pos_t pos);
		edit_item_t it;
		it.act = act;
		it.ch = ch;
		it.pos = pos;
		pending_edits.push_back(it);
		items_queued++;
		case (act)
			gbts_pkg::ACT_INSERT: if (plan_gs < plan_ge) plan_gs++;
			gbts_pkg::ACT_DELETE: if (plan_gs > 0) plan_gs--;
			gbts_pkg::ACT_LEFT: begin
				if (plan_gs > 0) begin
					plan_gs--;
					plan_ge--;
				end
			end
			gbts_pkg::ACT_RIGHT: begin
				if (plan_ge < CAPACITY) begin
					plan_gs++;
					plan_ge++;
				end
			end
			default: ;
		endcase
	endtask

	// Mostly positions inside the text, some anywhere in the field.
	function gbts_pkg::pos_t pick_position();
		if (plan_len() > 0 && $urandom_range(0, 4) != 0)
			return gbts_pkg::pos_t'($urandom_range(0, plan_len() - 1));
		return gbts_pkg::pos_t'($urandom_range(0, 1023));
	endfunction

	// Random edits with weights in percent; what is left over goes to the
	// spare codes. stop_full ends the run of edits once the text is full.
	task queue_random(input int n, input int w_ins, input int w_del, input int w_mov,
			input int w_rd, input bit stop_full);
		int i;
		int r;
		gbts_pkg::action_t act;
		for (i = 0; i < n; i++) begin
			if (stop_full && plan_len() == CAPACITY)
				break;
			r = $urandom_range(0, 99);
			if (r < w_ins)
				act = gbts_pkg::ACT_INSERT;
			else if (r < w_ins + w_del)
				act = gbts_pkg::ACT_DELETE;
			else if (r < w_ins + w_del + w_mov)
				act = $urandom_range(0, 1) ? gbts_pkg::ACT_LEFT : gbts_pkg::ACT_RIGHT;
			else if (r < w_ins + w_del + w_mov + w_rd)
				act = gbts_pkg::ACT_READ;
			else
				act = gbts_pkg::action_t'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
			queue_edit(act, gbts_pkg::char_t'($urandom_range(0, 255)), pick_position());
		end
	endtask

	// Stimulus
	initial begin
		// empty buffer: every edge and range case, spare codes
		queue_edit(gbts_pkg::ACT_READ, 8'h3C, 10'd0);
		queue_edit(gbts_pkg::ACT_READ, 8'h00, 10'd1023);
		queue_edit(gbts_pkg::ACT_DELETE, 8'hFF, 10'd1023);
		queue_edit(gbts_pkg::ACT_LEFT, 8'h81, 10'd512);
		queue_edit(gbts_pkg::ACT_RIGHT, 8'h7E, 10'd341);
		queue_edit(ACT_SPARE_LO, 8'hFF, 10'd1023);
		queue_edit(ACT_SPARE_MID, 8'h55, 10'd682);
		queue_edit(ACT_SPARE_HI, 8'hAA, 10'd0);
		// text 00 FF A5, then reads on both sides of the text end
		queue_edit(gbts_pkg::ACT_INSERT, 8'h00, 10'd1023);
		queue_edit(gbts_pkg::ACT_INSERT, 8'hFF, 10'd0);
		queue_edit(gbts_pkg::ACT_INSERT, 8'hA5, 10'd777);
		queue_edit(gbts_pkg::ACT_READ, 8'h12, 10'd0);
		queue_edit(gbts_pkg::ACT_READ, 8'h34, 10'd2);
		queue_edit(gbts_pkg::ACT_READ, 8'h56, 10'd3);
		// cursor back to 1, then read across the gap
		queue_edit(gbts_pkg::ACT_LEFT, 8'h00, 10'd0);
		queue_edit(gbts_pkg::ACT_LEFT, 8'hFF, 10'd1023);
		queue_edit(gbts_pkg::ACT_READ, 8'h00, 10'd0);
		queue_edit(gbts_pkg::ACT_READ, 8'h00, 10'd1);
		queue_edit(gbts_pkg::ACT_READ, 8'h00, 10'd2);
		queue_edit(gbts_pkg::ACT_RIGHT, 8'h99, 10'd100);
		queue_edit(gbts_pkg::ACT_DELETE, 8'h66, 10'd200);
		queue_edit(gbts_pkg::ACT_RIGHT, 8'h00, 10'd300);
		queue_edit(gbts_pkg::ACT_RIGHT, 8'h00, 10'd400);
		queue_edit(gbts_pkg::ACT_INSERT, 8'h5A, 10'd0);
		queue_edit(gbts_pkg::ACT_READ, 8'h00, 10'd2);
		// fill to capacity, work a full buffer, then shrink it with a delete-heavy mix
		queue_random(2000, 88, 2, 6, 2, 1'b1);
		queue_random(150, 30, 10, 30, 28, 1'b0);
		queue_random(ITEM_TARGET - items_queued, 10, 40, 24, 24, 1'b0);
	end

	// Driver: bursts of random length, random idle gaps between them.
	edit_item_t next_edit;
	int         burst_left = 0;
	int         idle_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				apply_edit(action, data_char, position);
			if (idle_left > 0) begin
				idle_left--;
				in_valid <= 1'b0;
			end else if (pending_edits.size() > 0) begin
				next_edit = pending_edits.pop_front();
				action <= next_edit.act;
				data_char <= next_edit.ch;
				position <= next_edit.pos;
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: the stall pattern rotates, on rx_tick[7:6], through always
	// ready, coin flip, one cycle in four, and mostly ready. hold_off
	// overrides it for the long back-pressure stretch.
	logic [7:0] rx_tick = '0;
	logic       hold_off = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_tick <= '0;
		end else begin
			rx_tick <= rx_tick + 8'd1;
			if (hold_off)
				out_ready <= 1'b0;
			else
				case (rx_tick[7:6])
					2'd0: out_ready <= 1'b1;
					2'd1: out_ready <= $urandom_range(0, 1);
					2'd2: out_ready <= (rx_tick[1:0] == 2'd0);
					default: out_ready <= ($urandom_range(0, 3) != 0);
				endcase
		end
	end

	// Long hold-off partway through the fill, while the sender keeps going.
	initial begin
		while (results_seen < 700)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Monitor
	edit_result_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				report_error($sformatf("unexpected result: status %0d cursor %0d",
					status, cursor));
			end else begin
				want = expected_results.pop_front();
				if (read_char !== want.rd)
					report_error($sformatf("result %0d read_char %h, want %h",
						results_seen, read_char, want.rd));
				if (status !== want.st)
					report_error($sformatf("result %0d status %0d, want %0d",
						results_seen, status, want.st));
				if (cursor !== want.cur)
					report_error($sformatf("result %0d cursor %0d, want %0d",
						results_seen, cursor, want.cur));
				if (text_length !== want.len)
					report_error($sformatf("result %0d text_length %0d, want %0d",
						results_seen, text_length, want.len));
			end
		end
	end

	// End of run: everything sent and answered, then a short drain.
	initial begin
		@(posedge arst_n);
		while (pending_edits.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("TIMEOUT: %0d results still pending", expected_results.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

FILE: gap_buffer_text_store.f
src/gbts_pkg.sv
src/gap_buffer_text_store.sv
src/gbts_checker.sv
test/tb_gap_buffer_text_store.sv
